FILE: hw/rtl/stq_pkg.sv
package stq_pkg;

	// Field widths of the request and result ports
	localparam int REQ_W   = 2;
	localparam int ID_W    = 4;
	localparam int DELAY_W = 31;
	localparam int TIME_W  = 32;
	localparam int KIND_W  = 2;

	localparam int NUM_TIMERS_DEF = 16;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_SET    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CANCEL = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_STATUS    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EXPIRED   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_IDLE_TICK = 2'd2;

	// Status codes
	localparam logic ST_OK          = 1'b0;
	localparam logic ST_NOT_PENDING = 1'b1;

endpackage

FILE: hw/rtl/stq_entry_ram.sv
module stq_entry_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 36
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/stq_time_cmp.sv
module stq_time_cmp (
	input  logic [stq_pkg::TIME_W-1:0] a,
	input  logic [stq_pkg::TIME_W-1:0] b,
	output logic                       later
);
	import stq_pkg::*;

	logic [TIME_W-1:0] diff;

	// a is later than b when the wrapped difference is positive as a signed value
	assign diff  = a - b;
	assign later = (diff != '0) && !diff[TIME_W-1];

endmodule

FILE: hw/rtl/sorted_timer_queue.sv
// Sorted one-shot timer queue. A request is transferred at a rising edge with start high and
// busy low; busy then stays high until the request has been served. Results come out one per
// cycle on result_strobe and cannot be held off, so the receiver must take each one in the
// cycle it is shown; last marks the final result of a request. Clear, a set of an id outside
// the timer range and a cancel of an idle timer answer in the cycle after the transfer and
// leave busy low. A set of an idle timer runs the insert pass (LINK), a set of an armed timer
// first removes it from the list (UNLINK) and then inserts it anew, and a cancel of an armed
// timer runs the removal pass alone; busy stays high through these passes and the result
// follows in the next cycle. A tick sweeps the head of the list while entries are due; its
// results come out back to back, the last one in the cycle after the sweep, and when any timer
// expired it then closes the list up (COMPACT) over the expired entries. The list RAM, with its
// single read port and one entry per cycle, and the one wrap-safe time comparator set the pace
// of these passes.
module sorted_timer_queue #(
	parameter int NUM_TIMERS = stq_pkg::NUM_TIMERS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [stq_pkg::REQ_W-1:0]   req_type,
	input  logic [stq_pkg::ID_W-1:0]    timer_id,
	input  logic [stq_pkg::DELAY_W-1:0] delay_ms,
	input  logic [stq_pkg::TIME_W-1:0]  now_ms,
	output logic                        busy,
	output logic                        result_strobe,
	output logic [stq_pkg::KIND_W-1:0]  result_kind,
	output logic                        status,
	output logic [stq_pkg::ID_W-1:0]    expired_id,
	output logic                        last
);
	import stq_pkg::*;

	localparam int IDW = $clog2(NUM_TIMERS);
	localparam int AW  = IDW;
	localparam int CW  = $clog2(NUM_TIMERS + 1);
	localparam int EW  = IDW + TIME_W;

	// UNLINK: remove the addressed timer, closing the gap behind it.
	// LINK:   insert the new entry after every entry that is not later.
	// TICK:   walk the head of the list while entries are due.
	// COMPACT: shift the remaining entries down over the expired ones.
	typedef enum logic [2:0] {
		S_IDLE,
		S_UNLINK,
		S_LINK,
		S_TICK,
		S_COMPACT
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       ptr_q;
	logic [CW-1:0]       pidx_q;
	logic                pv_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       k_q;
	logic [TIME_W-1:0]   key_q;
	logic [IDW-1:0]      tgt_q;
	logic                is_set_q;
	logic                flag_q;
	logic [EW-1:0]       carry_q;
	logic [IDW-1:0]      hold_id_q;
	logic [NUM_TIMERS-1:0] armed_q;

	logic                strobe_q;
	logic [KIND_W-1:0]   kind_q;
	logic                status_q;
	logic [ID_W-1:0]     eid_q;
	logic                last_q;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [EW-1:0]       ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [EW-1:0]       ram_rdata;

	logic [IDW-1:0]      rd_id;
	logic [TIME_W-1:0]   rd_exp;
	logic                rd_later;
	logic                issue;
	logic                scan_done;
	logic                id_ok;
	logic [IDW-1:0]      tid;

	// List entries: timer id in the upper bits, absolute expiry below
	stq_entry_ram #(
		.DEPTH(NUM_TIMERS),
		.WIDTH(EW)
	) u_list (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_id  = ram_rdata[EW-1:TIME_W];
	assign rd_exp = ram_rdata[TIME_W-1:0];

	// One comparator serves both the insert search and the expiry sweep
	stq_time_cmp u_cmp (
		.a    (rd_exp),
		.b    (key_q),
		.later(rd_later)
	);

	assign tid   = IDW'(timer_id);
	assign id_ok = int'(timer_id) < NUM_TIMERS;

	// Read the list in order, one entry a cycle, up to the fill count
	assign issue     = (state_q != S_IDLE) && (ptr_q < cnt_q);
	assign scan_done = !pv_q && !issue;
	assign ram_raddr = ptr_q[AW-1:0];
	assign busy      = (state_q != S_IDLE);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pidx_q[AW-1:0];
		ram_wdata = ram_rdata;
		case (state_q)
			S_UNLINK: begin
				// Once the target is passed, move each entry down by one
				ram_we    = pv_q && flag_q;
				ram_waddr = AW'(pidx_q - 1'b1);
			end
			S_LINK: begin
				if (pv_q) begin
					if (flag_q) begin
						ram_we    = 1'b1;
						ram_wdata = carry_q;
					end else if (rd_later) begin
						ram_we    = 1'b1;
						ram_wdata = {tgt_q, key_q};
					end
				end else if (scan_done) begin
					// Append the displaced tail entry, or the new one if nothing was later
					ram_we    = 1'b1;
					ram_waddr = cnt_q[AW-1:0];
					ram_wdata = flag_q ? carry_q : {tgt_q, key_q};
				end
			end
			S_COMPACT: begin
				ram_we    = pv_q;
				ram_waddr = AW'(pidx_q - k_q);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ptr_q     <= '0;
			pidx_q    <= '0;
			pv_q      <= 1'b0;
			cnt_q     <= '0;
			k_q       <= '0;
			key_q     <= '0;
			tgt_q     <= '0;
			flag_q    <= 1'b0;
			is_set_q  <= 1'b0;
			carry_q   <= '0;
			hold_id_q <= '0;
			armed_q   <= '0;
			strobe_q  <= 1'b0;
			kind_q    <= KIND_STATUS;
			status_q  <= ST_OK;
			eid_q     <= '0;
			last_q    <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			pv_q     <= issue;
			pidx_q   <= ptr_q;
			if (issue) begin
				ptr_q <= ptr_q + 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					if (start) begin
						tgt_q  <= tid;
						ptr_q  <= '0;
						pv_q   <= 1'b0;
						flag_q <= 1'b0;
						k_q    <= '0;
						case (req_type)
							REQ_SET: begin
								key_q    <= now_ms + TIME_W'(delay_ms);
								is_set_q <= 1'b1;
								if (!id_ok) begin
									strobe_q <= 1'b1;
									kind_q   <= KIND_STATUS;
									status_q <= ST_OK;
									eid_q    <= '0;
									last_q   <= 1'b1;
								end else if (armed_q[tid]) begin
									state_q <= S_UNLINK;
								end else begin
									state_q <= S_LINK;
								end
							end
							REQ_CANCEL: begin
								is_set_q <= 1'b0;
								if (id_ok && armed_q[tid]) begin
									state_q <= S_UNLINK;
								end else begin
									strobe_q <= 1'b1;
									kind_q   <= KIND_STATUS;
									status_q <= ST_NOT_PENDING;
									eid_q    <= '0;
									last_q   <= 1'b1;
								end
							end
							REQ_TICK: begin
								key_q   <= now_ms;
								state_q <= S_TICK;
							end
							default: begin
								// Clear: drop every timer at once
								armed_q  <= '0;
								cnt_q    <= '0;
								strobe_q <= 1'b1;
								kind_q   <= KIND_STATUS;
								status_q <= ST_OK;
								eid_q    <= '0;
								last_q   <= 1'b1;
							end
						endcase
					end
				end
				S_UNLINK: begin
					if (pv_q && (rd_id == tgt_q)) begin
						flag_q <= 1'b1;
					end
					if (scan_done) begin
						cnt_q          <= cnt_q - 1'b1;
						armed_q[tgt_q] <= 1'b0;
						if (is_set_q) begin
							state_q <= S_LINK;
							ptr_q   <= '0;
							flag_q  <= 1'b0;
						end else begin
							state_q  <= S_IDLE;
							strobe_q <= 1'b1;
							kind_q   <= KIND_STATUS;
							status_q <= ST_OK;
							eid_q    <= '0;
							last_q   <= 1'b1;
						end
					end
				end
				S_LINK: begin
					if (pv_q) begin
						if (flag_q) begin
							carry_q <= ram_rdata;
						end else if (rd_later) begin
							carry_q <= ram_rdata;
							flag_q  <= 1'b1;
						end
					end
					if (scan_done) begin
						cnt_q          <= cnt_q + 1'b1;
						armed_q[tgt_q] <= 1'b1;
						state_q        <= S_IDLE;
						strobe_q       <= 1'b1;
						kind_q         <= KIND_STATUS;
						status_q       <= ST_OK;
						eid_q          <= '0;
						last_q         <= 1'b1;
					end
				end
				S_TICK: begin
					if (pv_q && !rd_later) begin
						// Due: disarm it and hold its id back in hold_id_q so that last is known
						armed_q[rd_id] <= 1'b0;
						k_q            <= pidx_q + 1'b1;
						hold_id_q      <= rd_id;
						flag_q         <= 1'b1;
						if (flag_q) begin
							strobe_q <= 1'b1;
							kind_q   <= KIND_EXPIRED;
							status_q <= ST_OK;
							eid_q    <= ID_W'(hold_id_q);
							last_q   <= 1'b0;
						end
					end else if (pv_q || scan_done) begin
						// First entry not yet due, or list exhausted: close the sweep
						strobe_q <= 1'b1;
						kind_q   <= flag_q ? KIND_EXPIRED : KIND_IDLE_TICK;
						status_q <= ST_OK;
						eid_q    <= flag_q ? ID_W'(hold_id_q) : '0;
						last_q   <= 1'b1;
						pv_q     <= 1'b0;
						ptr_q    <= k_q;
						state_q  <= (k_q == '0) ? S_IDLE : S_COMPACT;
					end
				end
				S_COMPACT: begin
					if (scan_done) begin
						cnt_q   <= cnt_q - k_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_strobe = strobe_q;
	assign result_kind   = kind_q;
	assign status        = status_q;
	assign expired_id    = eid_q;
	assign last          = last_q;

endmodule

FILE: hw/rtl/stq_checker.sv
module stq_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        result_strobe,
	input logic [stq_pkg::KIND_W-1:0]  result_kind,
	input logic                        status,
	input logic [stq_pkg::ID_W-1:0]    expired_id,
	input logic                        last
);
	import stq_pkg::*;

	// A transfer is either answered at once or keeps the block busy
	a_accept_answered: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || result_strobe)
		else $error("request transfer neither answered nor held busy");

	// The final result of a request is not directly followed by another result unless a new transfer is taken
	a_quiet_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last && !(start && !busy) |=> !result_strobe)
		else $error("result shown after the final one without a new request");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (result_kind == KIND_STATUS) || (result_kind == KIND_EXPIRED)
			|| (result_kind == KIND_IDLE_TICK))
		else $error("undefined result kind");

	a_status_only_kind0: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && (status == ST_NOT_PENDING) |-> result_kind == KIND_STATUS)
		else $error("not-pending status on an expiry result");

	a_idle_tick_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && (result_kind == KIND_IDLE_TICK) |-> last && (expired_id == '0))
		else $error("empty tick result not final");

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (.*);
